>>> rtl/frh_pkg.sv
// Shared constants for the frequency ranked histogram.
`default_nettype none

package frh_pkg;

    localparam int SYM_W          = 8;
    localparam int OUT_COUNT_W    = 16;
    localparam int ALPHABET_DEF   = 256;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

endpackage

`default_nettype wire

>>> rtl/frequency_ranked_histogram.sv
// Byte histogram in a synchronous memory with ranked drain of its bins.
`default_nettype none

// The bins live in a memory of ALPHABET words of COUNT_BITS each with one
// write port and one registered read port. A per-bin flag, cleared at
// reset, marks bins that hold a written count; a bin without it reads as
// zero, so the block is ready as soon as reset is released, with no
// clearing pass. An add item reads the bin, then writes back the saturated
// increment; an add whose symbol lies outside the alphabet changes nothing.
// A drain item scans the bins: the scan reads one bin per cycle through the
// single memory read port, then the wait state compares the last bin and
// the done state hands the result to the output register and clears the
// winning bin. The block takes one item at a time; it accepts the next item
// while a result still waits in the output register, but holds the end of a
// drain until that register is free.
module frequency_ranked_histogram
#(
    parameter int ALPHABET   = frh_pkg::ALPHABET_DEF,
    parameter int COUNT_BITS = frh_pkg::COUNT_BITS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           func,
    input  wire logic [frh_pkg::SYM_W-1:0]      symbol,

    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [frh_pkg::SYM_W-1:0]           out_symbol,
    output logic [frh_pkg::OUT_COUNT_W-1:0]     out_count,
    output logic                                empty_res
);

    import frh_pkg::*;

    localparam int IDX_W = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(ALPHABET - 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ADD  = 5'b00010,
        ST_SCAN = 5'b00100,
        ST_WAIT = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [COUNT_BITS-1:0] bin_mem [ALPHABET];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  rd_bin_vld_reg;
    logic [ALPHABET-1:0]   bin_vld_reg, bin_vld_next;

    logic [IDX_W-1:0]      rd_addr;
    logic                  mem_we;
    logic [COUNT_BITS-1:0] mem_wdata;

    logic [IDX_W-1:0]      add_idx_reg, add_idx_next;
    logic [IDX_W-1:0]      scan_addr_reg, scan_addr_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [COUNT_BITS-1:0] best_reg, best_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic                  found_reg, found_next;

    logic                          out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]              out_symbol_reg, out_symbol_next;
    logic [OUT_COUNT_W-1:0]        out_count_reg, out_count_next;
    logic                          empty_reg, empty_next;

    logic                  in_acc;
    logic                  sym_in_range;
    logic [COUNT_BITS-1:0] cnt_cur;
    logic                  out_free;
    logic                  done_go;

    assign in_ready     = (state_reg == ST_IDLE);
    assign in_acc       = in_valid && in_ready;
    assign sym_in_range = ({1'b0, symbol} < (SYM_W + 1)'(ALPHABET));
    assign cnt_cur      = rd_bin_vld_reg ? rd_data_reg : '0;
    assign out_free     = !out_valid_reg || out_ready;
    assign done_go      = (state_reg == ST_DONE) && out_free;

    assign rd_addr   = (state_reg == ST_IDLE) ? symbol[IDX_W-1:0] : scan_addr_reg;
    assign mem_we    = (state_reg == ST_ADD);
    assign mem_wdata = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;

    // Bin storage: one write port for adds, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bin_mem[add_idx_reg] <= mem_wdata;
        end
        rd_data_reg <= bin_mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        bin_vld_next    = bin_vld_reg;
        add_idx_next    = add_idx_reg;
        scan_addr_next  = scan_addr_reg;
        cmp_idx_next    = scan_addr_reg;
        cmp_vld_next    = (state_reg == ST_SCAN);
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_symbol_next = out_symbol_reg;
        out_count_next  = out_count_reg;
        empty_next      = empty_reg;

        // Running maximum; >= in ascending order lets the larger byte win ties.
        if (cmp_vld_reg && (cnt_cur != '0) && (cnt_cur >= best_reg))
        begin
            best_next     = cnt_cur;
            best_idx_next = cmp_idx_reg;
            found_next    = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (func == FUNC_DRAIN)
                    begin
                        scan_addr_next = '0;
                        best_next      = '0;
                        best_idx_next  = '0;
                        found_next     = 1'b0;
                        state_next     = ST_SCAN;
                    end
                    else if (sym_in_range)
                    begin
                        add_idx_next = symbol[IDX_W-1:0];
                        state_next   = ST_ADD;
                    end
                end
            end
            ST_ADD:
            begin
                bin_vld_next[add_idx_reg] = 1'b1;
                state_next                = ST_IDLE;
            end
            ST_SCAN:
            begin
                scan_addr_next = scan_addr_reg + 1'b1;
                if (scan_addr_reg == LAST_IDX)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold the result until the output register is free.
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    empty_next      = !found_reg;
                    out_symbol_next = found_reg ? SYM_W'(best_idx_reg) : '0;
                    out_count_next  = found_reg ? OUT_COUNT_W'(best_reg) : '0;
                    if (found_reg)
                    begin
                        bin_vld_next[best_idx_reg] = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bin_vld_reg    <= '0;
            rd_bin_vld_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bin_vld_reg    <= bin_vld_next;
            rd_bin_vld_reg <= bin_vld_reg[rd_addr];
            cmp_vld_reg    <= cmp_vld_next;
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        add_idx_reg    <= add_idx_next;
        scan_addr_reg  <= scan_addr_next;
        cmp_idx_reg    <= cmp_idx_next;
        best_reg       <= best_next;
        best_idx_reg   <= best_idx_next;
        out_symbol_reg <= out_symbol_next;
        out_count_reg  <= out_count_next;
        empty_reg      <= empty_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_symbol = out_symbol_reg;
    assign out_count  = out_count_reg;
    assign empty_res  = empty_reg;

    // An empty result carries zero fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && empty_res) |-> (out_symbol == '0 && out_count == '0))
        else $error("empty result with nonzero fields");

    // A finished add leaves its bin marked as written.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |=> bin_vld_reg[$past(add_idx_reg)])
        else $error("added bin not marked written");

    // A drained bin reads as zero afterwards.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_go && found_reg) |=> !bin_vld_reg[$past(best_idx_reg)])
        else $error("drained bin not cleared");

    // A result is loaded only at the end of a drain.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_next && !out_valid_reg) |-> (state_reg == ST_DONE))
        else $error("result loaded outside drain");

endmodule

`default_nettype wire
